// ===== src/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

    // Widths of registers, fields and internal counters
    localparam int COUNT_BITS_DEF = 17;
    localparam int CFG_W          = 17;
    localparam int CFG_ADDR_W     = 3;
    localparam int TRIG_W         = 10;
    localparam int WIDTH_W        = 16;
    localparam int PERIOD_W       = 17;
    localparam int DIST_W         = 10;
    localparam int CM_W           = 7;
    localparam int QUOT_W         = 14;
    localparam int REM_W          = 6;

    // Width to distance conversion: d = (w * W_STEP + W_ROUND) / W_DIV
    localparam int W_STEP  = 10;
    localparam int W_ROUND = 29;
    localparam int W_DIV   = 58;

    // Rounding to whole centimetres: (d + CM_ROUND) * CM_RECIP >> CM_SHIFT
    localparam int CM_ROUND   = 5;
    localparam int CM_RECIP   = 3277;
    localparam int CM_RECIP_W = 12;
    localparam int CM_SHIFT   = 15;

    // Register reset values
    localparam int TRIG_LEN_RST  = 20;
    localparam int TIMEOUT_RST   = 60000;
    localparam int PERIOD_RST    = 65000;
    localparam int MIN_DIST_RST  = 20;
    localparam int MAX_DIST_RST  = 500;
    localparam int JUMP_RST      = 30;
    localparam int WATER_REF_RST = 1000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_FALL
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_OK     = 3'd1,
        EV_NOECHO = 3'd2,
        EV_LONG   = 3'd3,
        EV_RANGE  = 3'd4,
        EV_JUMP   = 3'd5
    } t_event;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRIG_LEN  = 3'd0,
        CFG_TIMEOUT   = 3'd1,
        CFG_PERIOD    = 3'd2,
        CFG_MIN_DIST  = 3'd3,
        CFG_MAX_DIST  = 3'd4,
        CFG_JUMP      = 3'd5,
        CFG_WATER_REF = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_len_us;
        logic [WIDTH_W-1:0]  echo_timeout_us;
        logic [PERIOD_W-1:0] period_us;
        logic [DIST_W-1:0]   min_dist_x10;
        logic [DIST_W-1:0]   max_dist_x10;
        logic [DIST_W-1:0]   jump_limit_x10;
        logic [DIST_W-1:0]   water_ref_x10;
    } t_cfg;

    typedef struct packed {
        logic              trig_out;
        logic              reading_valid;
        logic [DIST_W-1:0] dist_x10;
        logic [CM_W-1:0]   dist_cm;
        logic [DIST_W-1:0] water_x10;
        t_event            event_res;
    } t_result;

endpackage

// ===== src/uer_cfg.sv =====
`timescale 1ns / 1ps

module uer_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]   i_addr,
    input  logic [uer_pkg::CFG_W-1:0]        i_wdata,
    output uer_pkg::t_cfg                    o_cfg
);

    uer_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_len_us  <= uer_pkg::TRIG_W'(uer_pkg::TRIG_LEN_RST);
            r_cfg.echo_timeout_us <= uer_pkg::WIDTH_W'(uer_pkg::TIMEOUT_RST);
            r_cfg.period_us       <= uer_pkg::PERIOD_W'(uer_pkg::PERIOD_RST);
            r_cfg.min_dist_x10    <= uer_pkg::DIST_W'(uer_pkg::MIN_DIST_RST);
            r_cfg.max_dist_x10    <= uer_pkg::DIST_W'(uer_pkg::MAX_DIST_RST);
            r_cfg.jump_limit_x10  <= uer_pkg::DIST_W'(uer_pkg::JUMP_RST);
            r_cfg.water_ref_x10   <= uer_pkg::DIST_W'(uer_pkg::WATER_REF_RST);
        end else if (i_we) begin
            case (uer_pkg::t_cfg_idx'(i_addr))
                uer_pkg::CFG_TRIG_LEN:  r_cfg.trigger_len_us  <= i_wdata[uer_pkg::TRIG_W-1:0];
                uer_pkg::CFG_TIMEOUT:   r_cfg.echo_timeout_us <= i_wdata[uer_pkg::WIDTH_W-1:0];
                uer_pkg::CFG_PERIOD:    r_cfg.period_us       <= i_wdata[uer_pkg::PERIOD_W-1:0];
                uer_pkg::CFG_MIN_DIST:  r_cfg.min_dist_x10    <= i_wdata[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_MAX_DIST:  r_cfg.max_dist_x10    <= i_wdata[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_JUMP:      r_cfg.jump_limit_x10  <= i_wdata[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_WATER_REF: r_cfg.water_ref_x10   <= i_wdata[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/uer_core.sv =====
`timescale 1ns / 1ps

module uer_core #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_echo,
    input  uer_pkg::t_cfg    i_cfg,
    output uer_pkg::t_result o_result
);

    localparam int CMP_W     = (COUNT_BITS > uer_pkg::PERIOD_W) ? COUNT_BITS : uer_pkg::PERIOD_W;
    localparam int QW        = uer_pkg::QUOT_W;
    localparam int RW        = uer_pkg::REM_W;
    localparam int DW        = uer_pkg::DIST_W;
    localparam int CW        = uer_pkg::WIDTH_W;
    localparam int CM_NUM_W  = DW + 1;
    localparam int CM_PROD_W = CM_NUM_W + uer_pkg::CM_RECIP_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [RW-1:0]         INIT_REM = RW'(uer_pkg::W_STEP + uer_pkg::W_ROUND);

    uer_pkg::t_phase        r_phase, n_phase;
    logic [COUNT_BITS-1:0]  r_since, n_since;
    logic [CW-1:0]          r_count, n_count;
    logic [QW-1:0]          r_q, n_q;       // running quotient of the width conversion
    logic [RW-1:0]          r_rem, n_rem;   // running remainder
    logic [DW-1:0]          r_last, n_last;
    logic                   r_has, n_has;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uer_pkg::PH_IDLE;
            r_since <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_has   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_since <= n_since;
            r_count <= n_count;
            r_last  <= n_last;
            r_has   <= n_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        logic [CMP_W-1:0]     v_since_cmp;
        logic [CMP_W-1:0]     v_period_cmp;
        logic [QW-1:0]        v_diff;
        logic [RW:0]          v_rem_sum;
        logic [CM_NUM_W-1:0]  v_cm_num;
        logic [CM_PROD_W-1:0] v_cm_prod;
        logic                 v_trig;
        uer_pkg::t_event      v_ev;

        n_phase   = r_phase;
        n_since   = r_since;
        n_count   = r_count;
        n_q       = r_q;
        n_rem     = r_rem;
        n_last    = r_last;
        n_has     = r_has;
        v_diff    = '0;
        v_rem_sum = {1'b0, r_rem} + (RW + 1)'(uer_pkg::W_STEP);
        v_trig    = 1'b0;
        v_ev      = uer_pkg::EV_NONE;

        // saturating tick count since the last start
        if (r_since != CNT_MAX) begin
            n_since = r_since + 1'b1;
        end
        v_since_cmp  = CMP_W'(n_since);
        v_period_cmp = CMP_W'(i_cfg.period_us);

        case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (v_since_cmp >= v_period_cmp) begin
                    n_since = '0;
                    n_phase = uer_pkg::PH_TRIG;
                    n_count = CW'(1);
                    v_trig  = 1'b1;
                end
            end
            uer_pkg::PH_TRIG: begin
                if (r_count < CW'(i_cfg.trigger_len_us)) begin
                    n_count = r_count + 1'b1;
                    v_trig  = 1'b1;
                end else begin
                    n_phase = uer_pkg::PH_RISE;
                    n_count = '0;
                end
            end
            default: ;
        endcase

        // rise wait also runs on the tick that ends the trigger pulse
        if (n_phase == uer_pkg::PH_RISE) begin
            if (i_echo) begin
                n_phase = uer_pkg::PH_FALL;
                n_count = CW'(1);
                n_q     = '0;
                n_rem   = INIT_REM;
            end else begin
                n_count = n_count + 1'b1;
                if (n_count >= i_cfg.echo_timeout_us) begin
                    v_ev    = uer_pkg::EV_NOECHO;
                    n_phase = uer_pkg::PH_IDLE;
                    n_count = '0;
                end
            end
        end else if (n_phase == uer_pkg::PH_FALL) begin
            if (i_echo) begin
                if (r_count >= i_cfg.echo_timeout_us) begin
                    v_ev    = uer_pkg::EV_LONG;
                    n_phase = uer_pkg::PH_IDLE;
                    n_count = '0;
                end else begin
                    n_count = r_count + 1'b1;
                    if (v_rem_sum >= (RW + 1)'(uer_pkg::W_DIV)) begin
                        n_rem = RW'(v_rem_sum - (RW + 1)'(uer_pkg::W_DIV));
                        n_q   = r_q + 1'b1;
                    end else begin
                        n_rem = v_rem_sum[RW-1:0];
                    end
                end
            end else begin
                n_phase = uer_pkg::PH_IDLE;
                n_count = '0;
                v_diff  = (r_q > QW'(r_last)) ? (r_q - QW'(r_last)) : (QW'(r_last) - r_q);
                if (r_q < QW'(i_cfg.min_dist_x10) || r_q > QW'(i_cfg.max_dist_x10)) begin
                    v_ev = uer_pkg::EV_RANGE;
                end else if (r_has && v_diff > QW'(i_cfg.jump_limit_x10)) begin
                    v_ev = uer_pkg::EV_JUMP;
                end else begin
                    v_ev   = uer_pkg::EV_OK;
                    n_last = r_q[DW-1:0];
                    n_has  = 1'b1;
                end
            end
        end

        v_cm_num  = CM_NUM_W'(n_last) + CM_NUM_W'(uer_pkg::CM_ROUND);
        v_cm_prod = CM_PROD_W'(v_cm_num) * CM_PROD_W'(uer_pkg::CM_RECIP);

        o_result.trig_out      = v_trig;
        o_result.reading_valid = n_has;
        o_result.dist_x10      = n_last;
        o_result.dist_cm       = v_cm_prod[uer_pkg::CM_SHIFT +: uer_pkg::CM_W];
        o_result.water_x10     = (i_cfg.water_ref_x10 > n_last) ?
                                 (i_cfg.water_ref_x10 - n_last) : '0;
        o_result.event_res     = v_ev;
    end

endmodule

// ===== src/uer_obuf.sv =====
`timescale 1ns / 1ps

module uer_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  uer_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output uer_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_main_v, r_skid_v;
    uer_pkg::t_result r_main, r_skid;
    logic             v_pop;

    assign v_pop   = r_main_v & i_ready;
    assign o_ready = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (v_pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps

// Ultrasonic ranger driven by a stream of one-microsecond echo samples.
// Input channel: one beat per tick carrying i_echo_level (i_in_valid/o_in_ready).
// Output channel: exactly one result beat per input beat, in order
// (o_out_valid/i_out_ready): trigger level, reading flag, last accepted
// distance in tenths of cm, rounded cm, water level and an event code.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 trigger length .. 6 water reference); index 7 is ignored.
// A result is registered in the output buffer as its input beat is taken.
// Throughput: one beat per cycle while not stalled, set by a single pass
// through the phase counter, tick counter and width-to-distance quotient,
// kept as a running quotient and remainder so no divider sits in the path.
// Stall: a two-entry output buffer (result register plus skid) lets the
// block take one more beat while a result waits; o_in_ready drops only
// when both entries hold results.
// Reset (synchronous, active low): registers return to their defaults, the
// phase goes idle, counters and the last reading clear, buffers empty.
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_echo_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_trig_out,
    output logic                           o_reading_valid,
    output logic [uer_pkg::DIST_W-1:0]     o_dist_x10,
    output logic [uer_pkg::CM_W-1:0]       o_dist_cm,
    output logic [uer_pkg::DIST_W-1:0]     o_water_x10,
    output logic [2:0]                     o_event_res,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [uer_pkg::CFG_W-1:0]      i_cfg_wdata
);

    uer_pkg::t_cfg    w_cfg;
    uer_pkg::t_result w_result;
    uer_pkg::t_result w_out;
    logic             w_fire;

    // advance the ranger state on every accepted beat
    assign w_fire = i_in_valid & o_in_ready;

    uer_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    uer_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_echo   (i_echo_level),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // hold results here until the receiver takes them
    uer_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_ready (i_out_ready)
    );

    assign o_trig_out      = w_out.trig_out;
    assign o_reading_valid = w_out.reading_valid;
    assign o_dist_x10      = w_out.dist_x10;
    assign o_dist_cm       = w_out.dist_cm;
    assign o_water_x10     = w_out.water_x10;
    assign o_event_res     = w_out.event_res;

`ifndef SYNTHESIS
    // a full skid entry always sits behind a full result register
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output register");

    // an accepted reading is reflected in the same result
    a_ok_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == uer_pkg::EV_OK) |-> o_reading_valid)
        else $error("accepted reading without reading_valid");

    // a trigger tick never ends a measurement
    a_trig_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trig_out) |-> (o_event_res == uer_pkg::EV_NONE))
        else $error("event reported during trigger pulse");

    // no distance is shown before a reading exists
    a_no_reading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |-> (o_dist_x10 == '0 && o_dist_cm == '0))
        else $error("distance shown before any reading");
`endif

endmodule

// ===== tb/uer_checker.sv =====
`timescale 1ns / 1ps

module uer_checker
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_echo_level,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_trig_out,
    input  logic                  i_reading_valid,
    input  logic [DIST_W-1:0]     i_dist_x10,
    input  logic [CM_W-1:0]       i_dist_cm,
    input  logic [DIST_W-1:0]     i_water_x10,
    input  logic [2:0]            i_event_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_cfg                      settings;
    t_phase                    meas_phase;
    logic [COUNT_BITS_DEF-1:0] tick_count;
    logic [WIDTH_W-1:0]        phase_ticks;
    logic [DIST_W-1:0]         last_dist;
    logic                      dist_held;
    t_result                   owed_results[$];
    int                        fail_total;
    int                        result_beats;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("uer_checker: beat %0d: %s", result_beats, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // Convert an echo width to tenths of cm and decide whether it is kept.
    function automatic t_event judge_width(input logic [WIDTH_W-1:0] w);
        logic [QUOT_W-1:0] d_x10;
        logic [QUOT_W-1:0] gap;
        d_x10 = QUOT_W'((32'(w) * 10 + 29) / 58);
        if (d_x10 < settings.min_dist_x10 || d_x10 > settings.max_dist_x10) begin
            return EV_RANGE;
        end
        if (dist_held) begin
            gap = (d_x10 > last_dist) ? d_x10 - last_dist : last_dist - d_x10;
            if (gap > settings.jump_limit_x10) begin
                return EV_JUMP;
            end
        end
        last_dist = DIST_W'(d_x10);
        dist_held = 1'b1;
        return EV_OK;
    endfunction

    // Advance the ranger by one microsecond tick and form its result.
    function automatic t_result step_ranger(input logic echo);
        t_result r;
        logic    trig;
        t_event  ev;
        trig = 1'b0;
        ev   = EV_NONE;
        if (tick_count != '1) begin
            tick_count++;
        end
        case (meas_phase)
            PH_IDLE: begin
                if (tick_count >= settings.period_us) begin
                    tick_count  = '0;
                    meas_phase  = PH_TRIG;
                    phase_ticks = WIDTH_W'(1);
                    trig        = 1'b1;
                end
            end
            PH_TRIG: begin
                if (phase_ticks < WIDTH_W'(settings.trigger_len_us)) begin
                    phase_ticks++;
                    trig = 1'b1;
                end else begin
                    meas_phase  = PH_RISE;
                    phase_ticks = '0;
                end
            end
            default: ;
        endcase
        // The tick that ends the trigger is already a rise-wait sample.
        if (meas_phase == PH_RISE && !trig) begin
            if (echo) begin
                meas_phase  = PH_FALL;
                phase_ticks = WIDTH_W'(1);
            end else begin
                phase_ticks++;
                if (phase_ticks >= settings.echo_timeout_us) begin
                    ev          = EV_NOECHO;
                    meas_phase  = PH_IDLE;
                    phase_ticks = '0;
                end
            end
        end else if (meas_phase == PH_FALL) begin
            if (echo) begin
                if (phase_ticks >= settings.echo_timeout_us) begin
                    ev          = EV_LONG;
                    meas_phase  = PH_IDLE;
                    phase_ticks = '0;
                end else begin
                    phase_ticks++;
                end
            end else begin
                ev          = judge_width(phase_ticks);
                meas_phase  = PH_IDLE;
                phase_ticks = '0;
            end
        end
        r.trig_out      = trig;
        r.reading_valid = dist_held;
        r.dist_x10      = last_dist;
        r.dist_cm       = CM_W'((32'(last_dist) + 5) / 10);
        r.water_x10     = (settings.water_ref_x10 > last_dist) ?
                          settings.water_ref_x10 - last_dist : '0;
        r.event_res     = ev;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            settings.trigger_len_us  = TRIG_W'(TRIG_LEN_RST);
            settings.echo_timeout_us = WIDTH_W'(TIMEOUT_RST);
            settings.period_us       = PERIOD_W'(PERIOD_RST);
            settings.min_dist_x10    = DIST_W'(MIN_DIST_RST);
            settings.max_dist_x10    = DIST_W'(MAX_DIST_RST);
            settings.jump_limit_x10  = DIST_W'(JUMP_RST);
            settings.water_ref_x10   = DIST_W'(WATER_REF_RST);
            meas_phase   = PH_IDLE;
            tick_count   = '0;
            phase_ticks  = '0;
            last_dist    = '0;
            dist_held    = 1'b0;
            result_beats = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TRIG_LEN:  settings.trigger_len_us  = TRIG_W'(i_cfg_wdata);
                    CFG_TIMEOUT:   settings.echo_timeout_us = WIDTH_W'(i_cfg_wdata);
                    CFG_PERIOD:    settings.period_us       = PERIOD_W'(i_cfg_wdata);
                    CFG_MIN_DIST:  settings.min_dist_x10    = DIST_W'(i_cfg_wdata);
                    CFG_MAX_DIST:  settings.max_dist_x10    = DIST_W'(i_cfg_wdata);
                    CFG_JUMP:      settings.jump_limit_x10  = DIST_W'(i_cfg_wdata);
                    CFG_WATER_REF: settings.water_ref_x10   = DIST_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
            // Retire the result beat before queueing the new tick's result.
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = owed_results.pop_front();
                    compare_field("trig_out", i_trig_out, want.trig_out);
                    compare_field("reading_valid", i_reading_valid, want.reading_valid);
                    compare_field("dist_x10", i_dist_x10, want.dist_x10);
                    compare_field("dist_cm", i_dist_cm, want.dist_cm);
                    compare_field("water_x10", i_water_x10, want.water_x10);
                    compare_field("event_res", i_event_res, want.event_res);
                end
                result_beats++;
            end
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(step_ranger(i_echo_level));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= owed_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import uer_pkg::*;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 3'd7;
    // Ticks the random phases spend on each setting
    localparam int PHASE_TICKS    = 35;
    localparam int RANDOM_PHASES  = 6;
    // Bound the final drain in cycles
    localparam int DRAIN_LIMIT    = 100000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_echo_level;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_trig_out;
    logic                  o_reading_valid;
    logic [DIST_W-1:0]     o_dist_x10;
    logic [CM_W-1:0]       o_dist_cm;
    logic [DIST_W-1:0]     o_water_x10;
    logic [2:0]            o_event_res;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    int fail_cnt;
    int pending_cnt;
    int burst_left;
    int ticks_sent;

    ultrasonic_echo_ranger i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trig_out      (o_trig_out),
        .o_reading_valid (o_reading_valid),
        .o_dist_x10      (o_dist_x10),
        .o_dist_cm       (o_dist_cm),
        .o_water_x10     (o_water_x10),
        .o_event_res     (o_event_res),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Watch both channels and the register port; predict and compare.
    uer_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_echo_level    (i_echo_level),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_trig_out      (o_trig_out),
        .i_reading_valid (o_reading_valid),
        .i_dist_x10      (o_dist_x10),
        .i_dist_cm       (o_dist_cm),
        .i_water_x10     (o_water_x10),
        .i_event_res     (o_event_res),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_cnt),
        .o_pending       (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run; sized for every beat waiting out the longest stall.
    initial begin
        #8_000_000;
        $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

    // Result side: alternate free-flowing stretches, random stalls and,
    // now and then, a long hold-off so the output buffer fills and the
    // block pushes back on its input. Segment 40 always holds off.
    initial begin : result_sink
        int seg;
        int span;
        i_out_ready = 1'b0;
        seg = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            seg++;
            if (seg == 40 || $urandom_range(0, 39) == 0) begin
                span = $urandom_range(60, 150);
                i_out_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                span = $urandom_range(10, 60);
                i_out_ready <= 1'b1;
                repeat (span) @(posedge i_clk);
            end else begin
                span = $urandom_range(10, 60);
                repeat (span) begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_cfg make_settings(input int unsigned trig, input int unsigned timeout,
                                           input int unsigned period, input int unsigned dmin,
                                           input int unsigned dmax, input int unsigned jump,
                                           input int unsigned water);
        t_cfg s;
        s.trigger_len_us  = TRIG_W'(trig);
        s.echo_timeout_us = WIDTH_W'(timeout);
        s.period_us       = PERIOD_W'(period);
        s.min_dist_x10    = DIST_W'(dmin);
        s.max_dist_x10    = DIST_W'(dmax);
        s.jump_limit_x10  = DIST_W'(jump);
        s.water_ref_x10   = DIST_W'(water);
        return s;
    endfunction

    // Small settings so that a measurement takes a few dozen ticks and the
    // echo widths land near the distance window and jump limit.
    function automatic t_cfg pick_settings();
        int unsigned dmin;
        int unsigned dmax;
        int unsigned timeout;
        dmin    = $urandom_range(0, 4);
        // Invert the window now and then.
        dmax    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 12);
        timeout = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
        return make_settings($urandom_range(0, 3), timeout, $urandom_range(0, 6), dmin, dmax,
                             $urandom_range(0, 4),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 10));
    endfunction

    // Write every register; junk above a register's width must be dropped.
    task automatic load_settings(input t_cfg s);
        t_cfg_idx    regs[7];
        int unsigned vals[7];
        int          wbits[7];
        int unsigned junk;
        regs  = '{CFG_TRIG_LEN, CFG_TIMEOUT, CFG_PERIOD, CFG_MIN_DIST, CFG_MAX_DIST,
                  CFG_JUMP, CFG_WATER_REF};
        vals  = '{s.trigger_len_us, s.echo_timeout_us, s.period_us, s.min_dist_x10,
                  s.max_dist_x10, s.jump_limit_x10, s.water_ref_x10};
        wbits = '{TRIG_W, WIDTH_W, PERIOD_W, DIST_W, DIST_W, DIST_W, DIST_W};
        for (int k = 0; k < 7; k++) begin
            junk = ($urandom_range(0, 3) == 0) ? ($urandom << wbits[k]) : 0;
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= regs[k];
            i_cfg_wdata <= CFG_W'(vals[k] | junk);
            @(posedge i_clk);
        end
        if ($urandom_range(0, 1) == 0) begin
            i_cfg_addr  <= CFG_SPARE_IDX;
            i_cfg_wdata <= CFG_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one tick; open a new burst, maybe after a gap, when one runs out.
    task automatic send_tick(input logic level);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_echo_level <= level;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        ticks_sent++;
    endtask

    // Play a fixed echo pattern, oldest tick in the top bit.
    task automatic play_bits(input logic [31:0] bits, input int n);
        for (int k = n - 1; k >= 0; k--) begin
            send_tick(bits[k]);
        end
    endtask

    // Stay quiet until every result is back, then settle before a write.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // One well-formed measurement: a low stretch long enough to get past
    // the period and trigger into the rise wait (sometimes long enough to
    // time out), then an echo pulse of random width, then low again.
    task automatic run_measurement(input t_cfg s);
        int unsigned lead;
        int unsigned width;
        lead  = s.period_us + ((s.trigger_len_us == 0) ? 1 : s.trigger_len_us)
                + $urandom_range(0, s.echo_timeout_us + 3);
        width = $urandom_range(1, s.echo_timeout_us + 2);
        repeat (lead) send_tick(1'b0);
        repeat (width) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    initial begin : stimulus
        t_cfg s;
        int   phase_start;
        int   waited;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_echo_level = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        burst_left   = 0;
        ticks_sent   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero trigger length and zero timeout behave as one; an inverted
        // window drops everything; zero reference floors the water level.
        // Covers no echo, echo too long and out of range before any reading.
        load_settings(make_settings(0, 0, 0, 30, 10, 0, 0));
        play_bits(32'b00011010010, 11);
        drain_results();

        // Short timeout, open window, jump limit of one tenth of a cm.
        load_settings(make_settings(1, 4, 2, 0, 1023, 1, 1023));
        play_bits(32'b00111000111111, 14);
        drain_results();

        // Long trigger and widest timeout: time a pulse that lands past a
        // small water reference, so the rounded cm and a zero water level
        // show up after a real reading.
        load_settings(make_settings(40, 65535, 1, 0, 1023, 1023, 10));
        repeat (45) send_tick(1'b0);
        repeat (90) send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain_results();

        // Random settings, mostly measurements with some raw noise mixed in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            s = pick_settings();
            load_settings(s);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(4, 16)) send_tick($urandom_range(0, 1));
                end else begin
                    run_measurement(s);
                end
            end
            drain_results();
        end

        // Longest period: no start within the run; other registers at or near
        // their far ends, window inverted.
        load_settings(make_settings(1000, 65535, 131071, 1023, 0, 1023, 1023));
        repeat (40) send_tick($urandom_range(0, 1));

        // Let the last results come back, then wait quietly before the verdict.
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("[ultrasonic_echo_ranger] OK");
        end else begin
            $display("[ultrasonic_echo_ranger] ERROR");
        end
        $finish;
    end

endmodule
